>>> design/smpd_pkg.sv
// ----------------------------------------------------------------------------
// smpd_pkg - shared types and codes for the serial mouse packet decoder
// Event kinds, input item kinds and the control bundle to the framer.
// ----------------------------------------------------------------------------
package smpd_pkg;

  // Hardware supports at most three buttons (left, right, middle).
  localparam int unsigned MAX_BUTTONS = 3;

  // Input item kind (carried on in_tuser)
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  // Result event kind (carried on out_tuser)
  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOTION  = 2'd2
  } event_kind_t;

  // Control from the top level to the framer
  typedef struct packed {
    logic       byte_en;   // a serial byte is transferred this cycle
    logic [7:0] rx_byte;   // that byte
    logic       accum_clr; // a poll consumed the motion accumulators
  } frame_ctl_t;

endpackage

>>> design/smpd_frame.sv
// ----------------------------------------------------------------------------
// smpd_frame - byte framing, motion accumulation and button capture
// Frames received bytes into packets, adds signed deltas into saturating
// accumulators on the third byte and tracks the button bits.
// ----------------------------------------------------------------------------
module smpd_frame import smpd_pkg::*; #(
  parameter int ACCUM_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  frame_ctl_t                    ctl,
  output logic [MAX_BUTTONS-1:0]        button_bits,
  output logic signed [ACCUM_WIDTH-1:0] accum_x,
  output logic signed [ACCUM_WIDTH-1:0] accum_y
);

  localparam logic [3:0] CNT_LIMIT = 4'd7;

  logic [3:0]                    cnt_r, cnt_nxt, cnt_base;
  logic [7:0]                    held0_r, held0_nxt, held1_r, held1_nxt;
  logic signed [ACCUM_WIDTH-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [MAX_BUTTONS-1:0]        btn_r, btn_nxt;
  logic signed [7:0]             dx, dy;

  // Saturating add of an 8-bit signed delta into the accumulator width.
  function automatic logic signed [ACCUM_WIDTH-1:0] sat_add(
    input logic signed [ACCUM_WIDTH-1:0] acc,
    input logic signed [7:0]             d
  );
    logic signed [ACCUM_WIDTH:0] s;
    s = $signed({acc[ACCUM_WIDTH-1], acc}) + (ACCUM_WIDTH+1)'(d);
    if (s[ACCUM_WIDTH] != s[ACCUM_WIDTH-1]) begin
      sat_add = {s[ACCUM_WIDTH], {(ACCUM_WIDTH-1){~s[ACCUM_WIDTH]}}};
    end else begin
      sat_add = s[ACCUM_WIDTH-1:0];
    end
  endfunction

  always_comb begin
    // sync bit or runaway packet restarts framing
    cnt_base  = (ctl.rx_byte[6] || cnt_r > CNT_LIMIT) ? 4'd0 : cnt_r;
    cnt_nxt   = cnt_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    btn_nxt   = btn_r;
    dx        = $signed({held0_r[1:0], held1_r[5:0]});
    dy        = $signed({held0_r[3:2], ctl.rx_byte[5:0]});
    if (ctl.accum_clr) begin
      ax_nxt = '0;
      ay_nxt = '0;
    end
    if (ctl.byte_en) begin
      cnt_nxt = cnt_base + 4'd1;
      if (cnt_base == 4'd0) held0_nxt = ctl.rx_byte;
      if (cnt_base == 4'd1) held1_nxt = ctl.rx_byte;
      if (cnt_base == 4'd2) begin
        ax_nxt  = sat_add(ax_r, dx);
        ay_nxt  = sat_add(ay_r, dy);
        btn_nxt = MAX_BUTTONS'({1'b0, held0_r[5:4]});
      end else if (cnt_base == 4'd3) begin
        btn_nxt[2] = ctl.rx_byte[5];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      held0_r <= '0;
      held1_r <= '0;
      ax_r    <= '0;
      ay_r    <= '0;
      btn_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      btn_r   <= btn_nxt;
    end
  end

  assign button_bits = btn_r;
  assign accum_x     = ax_r;
  assign accum_y     = ay_r;

endmodule

>>> design/serial_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder - three/four byte serial mouse decoder
// Frames serial mouse bytes, accumulates motion and turns polls into a
// stream of button press/release and motion events.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | tuser: action, tdata: rx_byte
//  out_    | master    | tuser: event_kind, tdata: index/move_x/move_y, tlast
//  cfg_    | slave     | cfg_data: enable (always ready)
//
//  A byte transfer updates the framer in the cycle it is taken.
//  A poll snapshots changed buttons and motion into a pending set; one event
//  per cycle moves from there into the output register when not stalled, so
//  a poll makes up to four result transfers. Bytes and polls are taken back
//  to back; a byte or poll waits while an earlier poll still has more than
//  one event pending, or while its last event cannot enter the stalled output.
//  Synchronous active-low reset clears framing, accumulators and buttons.
//  Output stalls hold the output register; no result is ever dropped.
//
module serial_mouse_packet_decoder import smpd_pkg::*; #(
  parameter int BUTTON_COUNT = 3,
  parameter int ACCUM_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,      // [0] action
  input  logic [7:0]  in_tdata,      // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,     // [1:0] event_kind
  output logic [39:0] out_tdata,     // [1:0] button_index, [19:2] move_x,
                                     // [37:20] move_y, [39:38] zero
  output logic        out_tlast,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data       // [0] enable
);

  localparam int MOVE_W = 18;
  localparam int EXT_W  = (ACCUM_WIDTH + 2 > MOVE_W) ? ACCUM_WIDTH + 2 : MOVE_W;
  // buttons beyond BUTTON_COUNT are tracked but never reported
  localparam logic [MAX_BUTTONS-1:0] BTN_MASK = MAX_BUTTONS'((1 << BUTTON_COUNT) - 1);

  logic                          enable_r;
  logic [MAX_BUTTONS-1:0]        rep_r;
  // pending events of the current poll
  logic [MAX_BUTTONS-1:0]        pend_btn_r, pend_btn_nxt;
  logic [MAX_BUTTONS-1:0]        pend_lvl_r;
  logic                          pend_mot_r, pend_mot_nxt;
  logic signed [MOVE_W-1:0]      pend_mx_r, pend_my_r;
  // output register
  logic                          ov_r;
  event_kind_t                   okind_r, okind_nxt;
  logic [1:0]                    oidx_r, oidx_nxt;
  logic signed [MOVE_W-1:0]      omx_r, omy_r, omx_nxt, omy_nxt;
  logic                          olast_r, olast_nxt;

  frame_ctl_t                    ctl;
  logic [MAX_BUTTONS-1:0]        btn_bits, changed;
  logic signed [ACCUM_WIDTH-1:0] ax, ay;
  logic signed [ACCUM_WIDTH+1:0] mx2, my2;
  logic signed [EXT_W-1:0]       mx_ext, my_ext;
  logic                          in_xfer, poll_go, load, p_any, p_single, has_motion;
  logic [1:0]                    p_cnt;

  smpd_frame #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .button_bits (btn_bits),
    .accum_x     (ax),
    .accum_y     (ay)
  );

  // pending bookkeeping; the output register refills whenever free or taken
  assign p_cnt    = 2'(pend_btn_r[0]) + 2'(pend_btn_r[1]) + 2'(pend_btn_r[2])
                  + 2'(pend_mot_r);
  assign p_any    = (p_cnt != 2'd0) || pend_btn_r[2];
  assign p_single = (p_cnt == 2'd1) && !(&pend_btn_r);
  assign load     = !ov_r || out_tready;

  assign in_tready = !p_any || (p_single && load);
  assign in_xfer   = in_tvalid && in_tready;
  assign poll_go   = in_xfer && (in_tuser == ACT_POLL) && enable_r;

  assign ctl.byte_en   = in_xfer && (in_tuser == ACT_BYTE);
  assign ctl.rx_byte   = in_tdata;
  assign ctl.accum_clr = poll_go && has_motion;

  // motion scaled by two; y axis is flipped
  assign has_motion = (ax != '0) || (ay != '0);
  assign mx2        = {ax[ACCUM_WIDTH-1], ax, 1'b0};
  assign my2        = -{ay[ACCUM_WIDTH-1], ay, 1'b0};
  assign mx_ext     = EXT_W'(mx2);
  assign my_ext     = EXT_W'(my2);
  assign changed    = (btn_bits ^ rep_r) & BTN_MASK;

  // pick the lowest pending button, then motion
  always_comb begin
    pend_btn_nxt = pend_btn_r;
    pend_mot_nxt = pend_mot_r;
    okind_nxt    = EV_MOTION;
    oidx_nxt     = 2'd0;
    omx_nxt      = pend_mx_r;
    omy_nxt      = pend_my_r;
    priority if (pend_btn_r[0]) begin
      oidx_nxt        = 2'd0;
      pend_btn_nxt[0] = 1'b0;
    end else if (pend_btn_r[1]) begin
      oidx_nxt        = 2'd1;
      pend_btn_nxt[1] = 1'b0;
    end else if (pend_btn_r[2]) begin
      oidx_nxt        = 2'd2;
      pend_btn_nxt[2] = 1'b0;
    end else begin
      pend_mot_nxt = 1'b0;
    end
    if (pend_btn_r != '0) begin
      okind_nxt = pend_lvl_r[oidx_nxt] ? EV_PRESS : EV_RELEASE;
      omx_nxt   = '0;
      omy_nxt   = '0;
    end
    olast_nxt = (pend_btn_nxt == '0) && !pend_mot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      rep_r      <= '0;
      pend_btn_r <= '0;
      pend_mot_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_valid) enable_r <= cfg_data;
      if (load) begin
        ov_r <= p_any;
      end
      // a poll is only taken once the pending set drains this cycle
      if (poll_go) begin
        rep_r      <= btn_bits;
        pend_btn_r <= changed;
        pend_mot_r <= has_motion;
      end else if (load && p_any) begin
        pend_btn_r <= pend_btn_nxt;
        pend_mot_r <= pend_mot_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (poll_go) begin
      pend_lvl_r <= btn_bits;
      pend_mx_r  <= mx_ext[MOVE_W-1:0];
      pend_my_r  <= my_ext[MOVE_W-1:0];
    end
    if (load && p_any) begin
      okind_r <= okind_nxt;
      oidx_r  <= oidx_nxt;
      omx_r   <= omx_nxt;
      omy_r   <= omy_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = {2'b00, omy_r, omx_r, oidx_r};
  assign out_tlast  = olast_r;

endmodule
